/* hw/rtl/reliable_inorder_receive_reorder_macros.svh */
// Assertion helpers for the RTL of the receive reorder block; only rirr_back includes them.
// Both macros expect signals named clk and arst_n in the enclosing scope.
`ifndef RELIABLE_INORDER_RECEIVE_REORDER_MACROS_SVH
`define RELIABLE_INORDER_RECEIVE_REORDER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RIRR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RIRR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/rirr_pkg.sv */
`timescale 1ns / 1ps

package rirr_pkg;

	localparam int REORDER_DEPTH = 32;
	localparam int SLOT_W = $clog2(REORDER_DEPTH);
	localparam int TAG_W = 16;
	localparam int SEQ_W = 32;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [SLOT_W:0] slotx_t;
	typedef logic [TAG_W-1:0] tag_t;
	typedef logic [SEQ_W-1:0] seq_t;

	typedef enum logic [2:0] {
		ACT_DELIVER  = 3'd0,
		ACT_DISCARD  = 3'd1,
		ACT_PARKED   = 3'd2,
		ACT_OVERFLOW = 3'd3,
		ACT_ACKREQ   = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		KIND_UNREL_DATA,
		KIND_UNREL_ACK,
		KIND_RELIABLE
	} kind_t;

	typedef enum logic [1:0] {
		ST_EXEC,
		ST_DUP,
		ST_DRAIN,
		ST_ACK
	} back_state_t;

	// One classified packet as it waits between the front and the back.
	typedef struct packed {
		tag_t  tag;
		kind_t kind;
		seq_t  seq;
		logic  bend;
		logic  sqe;
	} work_t;

	typedef struct packed {
		logic  valid;
		work_t item;
	} wq_head_t;

endpackage

/* hw/rtl/rirr_in_if.sv */
`timescale 1ns / 1ps

interface rirr_in_if import rirr_pkg::*; ();
	logic valid;
	logic ready;
	tag_t packet_tag;
	logic is_reliable;
	logic is_ack_type;
	seq_t reliable_seq;
	logic batch_end;
	logic send_queue_empty;

	modport source (
		output valid, packet_tag, is_reliable, is_ack_type, reliable_seq, batch_end,
		send_queue_empty,
		input ready
	);
	modport sink (
		input valid, packet_tag, is_reliable, is_ack_type, reliable_seq, batch_end,
		send_queue_empty,
		output ready
	);
endinterface

/* hw/rtl/rirr_out_if.sv */
`timescale 1ns / 1ps

interface rirr_out_if import rirr_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [2:0] action;
	tag_t       out_tag;
	seq_t       out_seq;
	logic       last_result;

	modport source (output valid, action, out_tag, out_seq, last_result, input ready);
	modport sink (input valid, action, out_tag, out_seq, last_result, output ready);
endinterface

/* hw/rtl/rirr_front.sv */
`timescale 1ns / 1ps

module rirr_front import rirr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	rirr_in_if.sink  pkt,
	input  logic     pop,
	output wq_head_t head
);

	work_t item_in;
	work_t head_item_q;
	work_t spare_item_q;
	logic  head_v_q;
	logic  spare_v_q;
	logic  push;

	always_comb begin
		item_in.tag  = pkt.packet_tag;
		item_in.seq  = pkt.reliable_seq;
		item_in.bend = pkt.batch_end;
		item_in.sqe  = pkt.send_queue_empty;
		if (pkt.is_reliable) begin
			item_in.kind = KIND_RELIABLE;
		end else if (pkt.is_ack_type) begin
			item_in.kind = KIND_UNREL_ACK;
		end else begin
			item_in.kind = KIND_UNREL_DATA;
		end
	end

	// Two-entry queue: the head feeds the back, the spare catches a beat while the head is busy.
	assign pkt.ready = !spare_v_q;
	assign push = pkt.valid && !spare_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q  <= 1'b0;
			spare_v_q <= 1'b0;
		end else if (pop) begin
			head_v_q  <= spare_v_q || push;
			spare_v_q <= spare_v_q && push;
		end else begin
			head_v_q  <= head_v_q || push;
			spare_v_q <= spare_v_q || (push && head_v_q);
		end
	end

	always_ff @(posedge clk) begin
		if (pop && spare_v_q) begin
			head_item_q <= spare_item_q;
		end else if (push && (!head_v_q || pop)) begin
			head_item_q <= item_in;
		end
		if (push && head_v_q && !(pop && !spare_v_q)) begin
			spare_item_q <= item_in;
		end
	end

	assign head = '{valid: head_v_q, item: head_item_q};

endmodule

/* hw/rtl/rirr_back.sv */
`timescale 1ns / 1ps
`include "reliable_inorder_receive_reorder_macros.svh"

module rirr_back import rirr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  wq_head_t   head,
	output logic       pop,
	rirr_out_if.source res
);

	typedef struct packed {
		action_t action;
		tag_t    tag;
		seq_t    seq;
		logic    last;
	} result_t;

	function automatic slot_t slot_inc(slot_t s);
		slot_t r;
		if (s == slot_t'(REORDER_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = s + 1'b1;
		end
		return r;
	endfunction

	back_state_t              st_q, st_d;
	seq_t                     last_q, last_d;
	slot_t                    nslot_q, nslot_d;
	logic                     saw_q, saw_d;
	logic [REORDER_DEPTH-1:0] slot_valid_q, slot_valid_d;
	tag_t                     slot_tag_q [REORDER_DEPTH];
	tag_t                     rd_tag_q;
	tag_t                     dup_tag_q;
	logic                     dup_cap;
	logic                     tag_we;
	logic                     out_v_q;
	result_t                  out_q, res_d;
	logic                     fire;
	logic                     can_emit;

	work_t  item;
	logic   rel;
	logic   last_max;
	seq_t   last_inc;
	seq_t   diff;
	logic   is_next;
	logic   is_ahead;
	logic   beyond;
	slotx_t park_off;
	slotx_t park_sum;
	slot_t  park_slot;
	slot_t  nslot_inc;
	logic   dup;
	slot_t  post_nslot;
	logic   post_atmax;
	logic   saw_eff;
	logic   drain_x, ack_x, tail_x;
	logic   drain_c, ack_c, tail_c;
	logic   cont;

	assign item      = head.item;
	assign rel       = item.kind == KIND_RELIABLE;
	assign last_max  = last_q == '1;
	assign last_inc  = last_q + 1'b1;
	assign nslot_inc = slot_inc(nslot_q);
	assign is_next   = (item.seq == last_inc) && !last_max;
	assign is_ahead  = item.seq > last_q;
	assign diff      = item.seq - last_q;
	assign beyond    = diff > seq_t'(REORDER_DEPTH);

	// Slot of a parked sequence, from the slot of last+1 and the distance; stays below 2*depth.
	assign park_off  = diff[SLOT_W:0] - 1'b1;
	assign park_sum  = {1'b0, nslot_q} + park_off;
	assign park_slot = (park_sum >= slotx_t'(REORDER_DEPTH)) ?
		slot_t'(park_sum - slotx_t'(REORDER_DEPTH)) : slot_t'(park_sum);

	assign dup        = rel && is_next && slot_valid_q[nslot_q];
	assign post_nslot = (rel && is_next) ? nslot_inc : nslot_q;
	assign post_atmax = (rel && is_next) ? (item.seq == '1) : last_max;
	assign saw_eff    = saw_q || rel;

	// Whether more results follow once the packet itself has been handled.
	assign drain_x = slot_valid_q[post_nslot] && !post_atmax;
	assign ack_x   = saw_eff && item.sqe;
	assign tail_x  = item.bend && (drain_x || ack_x);
	assign drain_c = slot_valid_q[nslot_q] && !last_max;
	assign ack_c   = saw_q && item.sqe;
	assign tail_c  = item.bend && (drain_c || ack_c);
	assign cont    = slot_valid_q[nslot_inc] && (last_inc != '1);

	assign can_emit = !out_v_q || res.ready;

	always_comb begin
		st_d         = st_q;
		last_d       = last_q;
		nslot_d      = nslot_q;
		saw_d        = saw_q;
		slot_valid_d = slot_valid_q;
		tag_we       = 1'b0;
		dup_cap      = 1'b0;
		pop          = 1'b0;
		fire         = 1'b0;
		res_d        = '{action: ACT_DISCARD, tag: item.tag, seq: item.seq, last: 1'b0};
		case (st_q)
			ST_EXEC: begin
				if (head.valid && can_emit) begin
					fire = 1'b1;
					case (item.kind)
						KIND_UNREL_DATA: begin
							res_d.action = ACT_DELIVER;
						end
						KIND_RELIABLE: begin
							if (is_next) begin
								res_d.action = ACT_DELIVER;
								last_d       = item.seq;
								nslot_d      = nslot_inc;
								if (dup) begin
									slot_valid_d[nslot_q] = 1'b0;
									dup_cap               = 1'b1;
								end
							end else if (is_ahead) begin
								if (beyond) begin
									res_d.action = ACT_OVERFLOW;
								end else if (slot_valid_q[park_slot]) begin
									res_d.action = ACT_DISCARD;
								end else begin
									res_d.action            = ACT_PARKED;
									slot_valid_d[park_slot] = 1'b1;
									tag_we                  = 1'b1;
								end
							end else begin
								res_d.action = ACT_DISCARD;
							end
						end
						default: begin
							res_d.action = ACT_DISCARD;
						end
					endcase
					res_d.last = !dup && !tail_x;
					saw_d      = saw_eff;
					if (dup) begin
						st_d = ST_DUP;
					end else if (tail_x) begin
						st_d = drain_x ? ST_DRAIN : ST_ACK;
					end else begin
						pop = 1'b1;
						if (item.bend) begin
							saw_d = 1'b0;
						end
					end
				end
			end
			ST_DUP: begin
				if (can_emit) begin
					fire         = 1'b1;
					res_d.action = ACT_DISCARD;
					res_d.tag    = dup_tag_q;
					res_d.last   = !tail_c;
					if (tail_c) begin
						st_d = drain_c ? ST_DRAIN : ST_ACK;
					end else begin
						st_d = ST_EXEC;
						pop  = 1'b1;
						if (item.bend) begin
							saw_d = 1'b0;
						end
					end
				end
			end
			ST_DRAIN: begin
				if (can_emit) begin
					fire                  = 1'b1;
					res_d.action          = ACT_DELIVER;
					res_d.tag             = rd_tag_q;
					res_d.seq             = last_inc;
					res_d.last            = !cont && !ack_c;
					slot_valid_d[nslot_q] = 1'b0;
					last_d                = last_inc;
					nslot_d               = nslot_inc;
					if (cont) begin
						st_d = ST_DRAIN;
					end else if (ack_c) begin
						st_d = ST_ACK;
					end else begin
						st_d  = ST_EXEC;
						pop   = 1'b1;
						saw_d = 1'b0;
					end
				end
			end
			ST_ACK: begin
				if (can_emit) begin
					fire         = 1'b1;
					res_d.action = ACT_ACKREQ;
					res_d.tag    = '0;
					res_d.seq    = last_q;
					res_d.last   = 1'b1;
					st_d         = ST_EXEC;
					pop          = 1'b1;
					saw_d        = 1'b0;
				end
			end
			default: begin
				st_d = ST_EXEC;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_EXEC;
			last_q       <= '0;
			nslot_q      <= slot_t'(1);
			saw_q        <= 1'b0;
			slot_valid_q <= '0;
			out_v_q      <= 1'b0;
		end else begin
			st_q         <= st_d;
			last_q       <= last_d;
			nslot_q      <= nslot_d;
			saw_q        <= saw_d;
			slot_valid_q <= slot_valid_d;
			if (fire) begin
				out_v_q <= 1'b1;
			end else if (res.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// The tag store is read at the slot of the next expected sequence. A parked
	// packet never lands in that slot, so the read never races a write.
	always_ff @(posedge clk) begin
		if (tag_we) begin
			slot_tag_q[park_slot] <= item.tag;
		end
		rd_tag_q <= slot_tag_q[nslot_d];
		if (dup_cap) begin
			dup_tag_q <= rd_tag_q;
		end
		if (fire) begin
			out_q <= res_d;
		end
	end

	assign res.valid       = out_v_q;
	assign res.action      = out_q.action;
	assign res.out_tag     = out_q.tag;
	assign res.out_seq     = out_q.seq;
	assign res.last_result = out_q.last;

	`RIRR_ASSERT_IMP(a_busy_holds_item, st_q != ST_EXEC, head.valid, "follow-up state without a packet")
	`RIRR_ASSERT_IMP(a_pop_on_last, pop, fire && res_d.last, "packet released before its last beat")
	`RIRR_ASSERT_IMP(a_drain_slot_ready, st_q == ST_DRAIN, slot_valid_q[nslot_q] && !last_max,
		"drain entered with no deliverable slot")
	`RIRR_ASSERT_NXT(a_last_monotonic, 1'b1, last_q >= $past(last_q), "delivered sequence moved back")

endmodule

/* hw/rtl/reliable_inorder_receive_reorder.sv */
// Beats wait in the two-entry front queue, which takes new ones until its spare entry is full.
// Each packet gives one result, plus one for a parked duplicate dropped on direct delivery, one
// per parked packet drained at batch end, and one for an ack request: 1 to REORDER_DEPTH+2 results.
// The back writes one result per cycle, unless held by res.ready, into a single output register.
// Reset: asynchronous; clears the queue, sequence state and all slot valid bits at once.
`timescale 1ns / 1ps

module reliable_inorder_receive_reorder import rirr_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	rirr_in_if.sink    pkt,
	rirr_out_if.source res
);

	wq_head_t head;
	logic     pop;

	rirr_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.pkt    (pkt),
		.pop    (pop),
		.head   (head)
	);

	rirr_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.res    (res)
	);

endmodule
